// File: hw/rtl/pwmt_pkg.sv
// Shared types, register codes and defaults for the PWM timer.
// No dependencies; used by every module of the block.
package pwmt_pkg;

    localparam int DEF_COUNT_WIDTH   = 16;
    localparam int DEF_CHANNEL_COUNT = 4;

    localparam int SEL_W  = 3;
    localparam int DATA_W = 16;
    localparam int PWM_W  = 4;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [SEL_W-1:0] REG_PSC   = 3'd0;
    localparam logic [SEL_W-1:0] REG_PER   = 3'd1;
    localparam logic [SEL_W-1:0] REG_CMP1  = 3'd2;
    localparam logic [SEL_W-1:0] REG_CMP2  = 3'd3;
    localparam logic [SEL_W-1:0] REG_CMP3  = 3'd4;
    localparam logic [SEL_W-1:0] REG_CMP4  = 3'd5;
    localparam logic [SEL_W-1:0] REG_CTRL  = 3'd6;
    localparam logic [SEL_W-1:0] REG_FORCE = 3'd7;

    typedef struct packed {
        logic              req_type;
        logic [SEL_W-1:0]  reg_sel;
        logic [DATA_W-1:0] write_data;
    } t_item;

endpackage

// File: hw/rtl/pwm_timer_with_preload.sv
// Top level of the four-channel up-counting PWM timer with preload registers.
// Depends on pwmt_pkg, pwmt_core and pwmt_cmp.
//
//  channel | valid / ready             | payload
//  --------+---------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_req_type, i_reg_sel, i_write_data
//  out     | o_out_valid / i_out_ready | o_pwm_out, o_count_value, o_update_event
//
// One item per cycle sustained while the output is not stalled.
// An input register feeds the state update, whose result lands in the output register.
// Reset clears the counters, both stage valids and the timer registers (period ones go to all ones).
// A stalled output holds its result; the input register still takes one more item if it is empty.
module pwm_timer_with_preload
    import pwmt_pkg::*;
#(
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH,
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [SEL_W-1:0]  i_reg_sel,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PWM_W-1:0]  o_pwm_out,
    output logic [DATA_W-1:0] o_count_value,
    output logic              o_update_event
);

    logic   r_in_vld, n_in_vld;
    t_item  r_in;
    logic   r_out_vld, n_out_vld;
    logic   advance;

    logic [COUNT_WIDTH-1:0]                    count;
    logic [CHANNEL_COUNT-1:0][COUNT_WIDTH-1:0] cmp;
    logic [CHANNEL_COUNT-1:0]                  en;
    logic                                      upd;
    logic [PWM_W-1:0]                          pwm;

    logic [PWM_W-1:0]  r_pwm;
    logic [DATA_W-1:0] r_count;
    logic              r_upd;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_comb begin
        n_in_vld = r_in_vld;
        if (i_in_valid && o_in_ready) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (advance) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.req_type   <= i_req_type;
            r_in.reg_sel    <= i_reg_sel;
            r_in.write_data <= i_write_data;
        end
        if (advance) begin
            r_pwm   <= pwm;
            r_count <= DATA_W'(count);
            r_upd   <= upd;
        end
    end

    pwmt_core #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .o_count (count),
        .o_cmp   (cmp),
        .o_en    (en),
        .o_upd   (upd)
    );

    pwmt_cmp #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_cmp (
        .i_count (count),
        .i_cmp   (cmp),
        .i_en    (en),
        .o_pwm   (pwm)
    );

    assign o_out_valid    = r_out_vld;
    assign o_pwm_out      = r_pwm;
    assign o_count_value  = r_count;
    assign o_update_event = r_upd;

    a_upd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_upd |-> r_count == '0)
        else $error("update event with non-zero counter");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld)
        else $error("pending item dropped");

endmodule

// File: hw/rtl/pwmt_core.sv
// Timer state: prescaler, main counter, preload and active registers, control.
// Depends on pwmt_pkg; next-state values feed the result register in the top level.
module pwmt_core
    import pwmt_pkg::*;
#(
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH,
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_step,
    input  t_item                                    i_item,
    output logic [COUNT_WIDTH-1:0]                   o_count,
    output logic [CHANNEL_COUNT-1:0][COUNT_WIDTH-1:0] o_cmp,
    output logic [CHANNEL_COUNT-1:0]                 o_en,
    output logic                                     o_upd
);

    logic [COUNT_WIDTH-1:0] r_psc_cnt, n_psc_cnt;
    logic [COUNT_WIDTH-1:0] r_cnt,     n_cnt;
    logic [COUNT_WIDTH-1:0] r_psc_act, n_psc_act;
    logic [COUNT_WIDTH-1:0] r_psc_sh,  n_psc_sh;
    logic [COUNT_WIDTH-1:0] r_per_act, n_per_act;
    logic [COUNT_WIDTH-1:0] r_per_sh,  n_per_sh;
    logic [CHANNEL_COUNT-1:0][COUNT_WIDTH-1:0] r_cmp_act, n_cmp_act;
    logic [CHANNEL_COUNT-1:0][COUNT_WIDTH-1:0] r_cmp_sh,  n_cmp_sh;
    logic                     r_run, n_run;
    logic [CHANNEL_COUNT-1:0] r_en,  n_en;
    logic                     load;
    logic [COUNT_WIDTH-1:0]   wdata;

    assign wdata = COUNT_WIDTH'(i_item.write_data);

    always_comb begin
        n_psc_cnt = r_psc_cnt;
        n_cnt     = r_cnt;
        n_psc_sh  = r_psc_sh;
        n_per_sh  = r_per_sh;
        n_cmp_sh  = r_cmp_sh;
        n_run     = r_run;
        n_en      = r_en;
        load      = 1'b0;
        if (i_item.req_type == REQ_TICK) begin
            if (r_run) begin
                if (r_psc_cnt >= r_psc_act) begin
                    n_psc_cnt = '0;
                    if (r_cnt >= r_per_act) begin
                        n_cnt = '0;
                        load  = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_psc_cnt = r_psc_cnt + 1'b1;
                end
            end
        end else begin
            case (i_item.reg_sel)
                REG_PSC: begin
                    n_psc_sh = wdata;
                end
                REG_PER: begin
                    n_per_sh = wdata;
                end
                REG_CTRL: begin
                    n_run = i_item.write_data[0];
                    n_en  = i_item.write_data[CHANNEL_COUNT:1];
                end
                REG_FORCE: begin
                    n_psc_cnt = '0;
                    n_cnt     = '0;
                    load      = 1'b1;
                end
                default: begin
                    for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        if (i_item.reg_sel == REG_CMP1 + SEL_W'(c)) begin
                            n_cmp_sh[c] = wdata;
                        end
                    end
                end
            endcase
        end
        n_psc_act = load ? r_psc_sh : r_psc_act;
        n_per_act = load ? r_per_sh : r_per_act;
        n_cmp_act = load ? r_cmp_sh : r_cmp_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psc_cnt <= '0;
            r_cnt     <= '0;
            r_psc_act <= '0;
            r_psc_sh  <= '0;
            r_per_act <= '1;
            r_per_sh  <= '1;
            r_cmp_act <= '0;
            r_cmp_sh  <= '0;
            r_run     <= 1'b0;
            r_en      <= '0;
        end else if (i_step) begin
            r_psc_cnt <= n_psc_cnt;
            r_cnt     <= n_cnt;
            r_psc_act <= n_psc_act;
            r_psc_sh  <= n_psc_sh;
            r_per_act <= n_per_act;
            r_per_sh  <= n_per_sh;
            r_cmp_act <= n_cmp_act;
            r_cmp_sh  <= n_cmp_sh;
            r_run     <= n_run;
            r_en      <= n_en;
        end
    end

    assign o_count = n_cnt;
    assign o_cmp   = n_cmp_act;
    assign o_en    = n_en;
    assign o_upd   = load;

    a_psc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_psc_cnt <= r_psc_act)
        else $error("prescale count beyond active prescaler");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_per_act)
        else $error("main count beyond active period");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_cnt) && $stable(r_cmp_act) && $stable(r_per_act))
        else $error("timer state moved without a transfer");

endmodule

// File: hw/rtl/pwmt_cmp.sv
// Output compare: one comparator per channel against the active compare value.
// Depends on pwmt_pkg; driven by pwmt_core.
module pwmt_cmp
    import pwmt_pkg::*;
#(
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH,
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic [COUNT_WIDTH-1:0]                    i_count,
    input  logic [CHANNEL_COUNT-1:0][COUNT_WIDTH-1:0] i_cmp,
    input  logic [CHANNEL_COUNT-1:0]                  i_en,
    output logic [PWM_W-1:0]                          o_pwm
);

    for (genvar c = 0; c < PWM_W; c++) begin : g_ch
        if (c < CHANNEL_COUNT) begin : g_used
            assign o_pwm[c] = i_en[c] && (i_count < i_cmp[c]);
        end else begin : g_unused
            assign o_pwm[c] = 1'b0;
        end
    end

endmodule
